// ===== hw/rtl/gdnc_pkg.sv =====
package gdnc_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int JDN_W   = 23;
   localparam int LEN_W   = 5;

   // opcodes
   localparam logic OP_DATE_TO_JDN = 1'b0;
   localparam logic OP_JDN_TO_DATE = 1'b1;

   // supported ranges
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
   localparam logic [JDN_W-1:0]   JDN_MIN   = 23'd1721426;
   localparam logic [JDN_W-1:0]   JDN_MAX   = 23'd5373484;

   // one result word
   typedef struct packed {
      logic [JDN_W-1:0]   day_number;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               leap;
      logic [LEN_W-1:0]   month_length;
      logic               out_of_range;
   } rsp_word_type;

   // (367 * mm) / 12 with mm the month counted from March (Jan = 11, Feb = 12)
   function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] month);
      logic [8:0] term;
      case (month)
         4'd1:    term = 9'd336;
         4'd2:    term = 9'd367;
         4'd3:    term = 9'd30;
         4'd4:    term = 9'd61;
         4'd5:    term = 9'd91;
         4'd6:    term = 9'd122;
         4'd7:    term = 9'd152;
         4'd8:    term = 9'd183;
         4'd9:    term = 9'd214;
         4'd10:   term = 9'd244;
         4'd11:   term = 9'd275;
         4'd12:   term = 9'd305;
         default: term = 9'd0;
      endcase
      return term;
   endfunction

   // (2447 * j) / 80
   function automatic logic [8:0] j_term(input logic [3:0] j);
      logic [8:0] term;
      case (j)
         4'd0:    term = 9'd0;
         4'd1:    term = 9'd30;
         4'd2:    term = 9'd61;
         4'd3:    term = 9'd91;
         4'd4:    term = 9'd122;
         4'd5:    term = 9'd152;
         4'd6:    term = 9'd183;
         4'd7:    term = 9'd214;
         4'd8:    term = 9'd244;
         4'd9:    term = 9'd275;
         4'd10:   term = 9'd305;
         4'd11:   term = 9'd336;
         4'd12:   term = 9'd367;
         4'd13:   term = 9'd397;
         4'd14:   term = 9'd428;
         default: term = 9'd458;
      endcase
      return term;
   endfunction

   // days in a month
   function automatic logic [LEN_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [LEN_W-1:0] days;
      case (month)
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== hw/rtl/gregorian_day_number_convert_unit.sv =====
// Gregorian date / Julian Day Number converter. Opcode 0 takes year, month and day and
// returns the day number; opcode 1 takes a day number and returns year, month and day.
// Every result carries the day number, the (normalised) date, the leap-year flag and the
// month length; an input outside the supported range returns a word with only
// out_of_range set. The converter is a 17-stage pipeline of constant multiplies, with
// the divides for n, i and j done as a reciprocal multiply and one correcting compare and
// the divides by 100 as a reciprocal multiply alone, followed by an output register: it
// takes one word per clock while req_stall is low. A two-word output buffer (output
// register plus skid) lets the pipeline take one more word after the result side stalls;
// req_stall is raised only once the skid register holds a word.
module gregorian_day_number_convert_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [gdnc_pkg::YEAR_W-1:0]   req_in_year,
   input  logic [gdnc_pkg::MONTH_W-1:0]  req_in_month,
   input  logic [gdnc_pkg::DAY_W-1:0]    req_in_day,
   input  logic [gdnc_pkg::JDN_W-1:0]    req_in_day_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gdnc_pkg::JDN_W-1:0]    rsp_result_day_number,
   output logic [gdnc_pkg::YEAR_W-1:0]   rsp_result_year,
   output logic [gdnc_pkg::MONTH_W-1:0]  rsp_result_month,
   output logic [gdnc_pkg::DAY_W-1:0]    rsp_result_day,
   output logic                          rsp_leap_year_flag,
   output logic [gdnc_pkg::LEN_W-1:0]    rsp_month_length,
   output logic                          rsp_out_of_range
);
   import gdnc_pkg::*;

   localparam int STAGES = 17;

   // handshake
   logic              advance;
   logic              req_accept;
   logic              take;
   logic              leave;
   logic [STAGES-1:0] stage_valid_ff;

   // stage registers and next values
   logic              s1_op_ff,  s1_op_in;
   logic              s1_bad_ff, s1_bad_in;
   logic [13:0]       s1_ya_ff,  s1_ya_in;
   logic [13:0]       s1_yb_ff,  s1_yb_in;
   logic [9:0]        s1_k1_ff,  s1_k1_in;
   logic [JDN_W-1:0]  s1_jdi_ff, s1_jdi_in;

   logic              s2_op_ff,  s2_op_in;
   logic              s2_bad_ff, s2_bad_in;
   logic [24:0]       s2_p1_ff,  s2_p1_in;
   logic [26:0]       s2_cm_ff,  s2_cm_in;
   logic [9:0]        s2_k1_ff,  s2_k1_in;
   logic [JDN_W-1:0]  s2_jdi_ff, s2_jdi_in;

   logic              s3_bad_ff, s3_bad_in;
   logic [JDN_W-1:0]  s3_jd_ff,  s3_jd_in;

   logic              s4_bad_ff, s4_bad_in;
   logic [JDN_W-1:0]  s4_jd_ff,  s4_jd_in;
   logic [22:0]       s4_l_ff,   s4_l_in;

   logic              s5_bad_ff, s5_bad_in;
   logic [JDN_W-1:0]  s5_jd_ff,  s5_jd_in;
   logic [22:0]       s5_l_ff,   s5_l_in;
   logic [32:0]       s5_mq_ff,  s5_mq_in;

   logic              s6_bad_ff, s6_bad_in;
   logic [JDN_W-1:0]  s6_jd_ff,  s6_jd_in;
   logic [22:0]       s6_l_ff,   s6_l_in;
   logic [7:0]        s6_q_ff,   s6_q_in;
   logic [25:0]       s6_pr_ff,  s6_pr_in;

   logic              s7_bad_ff, s7_bad_in;
   logic [JDN_W-1:0]  s7_jd_ff,  s7_jd_in;
   logic [22:0]       s7_l_ff,   s7_l_in;
   logic [7:0]        s7_n_ff,   s7_n_in;
   logic [25:0]       s7_pn_ff,  s7_pn_in;

   logic              s8_bad_ff, s8_bad_in;
   logic [JDN_W-1:0]  s8_jd_ff,  s8_jd_in;
   logic [7:0]        s8_n_ff,   s8_n_in;
   logic [15:0]       s8_l2_ff,  s8_l2_in;

   logic              s9_bad_ff, s9_bad_in;
   logic [JDN_W-1:0]  s9_jd_ff,  s9_jd_in;
   logic [7:0]        s9_n_ff,   s9_n_in;
   logic [15:0]       s9_l2_ff,  s9_l2_in;
   logic [35:0]       s9_mi_ff,  s9_mi_in;
   logic [27:0]       s9_x2_ff,  s9_x2_in;

   logic              s10_bad_ff, s10_bad_in;
   logic [JDN_W-1:0]  s10_jd_ff,  s10_jd_in;
   logic [7:0]        s10_n_ff,   s10_n_in;
   logic [15:0]       s10_l2_ff,  s10_l2_in;
   logic [27:0]       s10_x2_ff,  s10_x2_in;
   logic [7:0]        s10_i_ff,   s10_i_in;
   logic [28:0]       s10_pi_ff,  s10_pi_in;

   logic              s11_bad_ff, s11_bad_in;
   logic [JDN_W-1:0]  s11_jd_ff,  s11_jd_in;
   logic [7:0]        s11_n_ff,   s11_n_in;
   logic [15:0]       s11_l2_ff,  s11_l2_in;
   logic [7:0]        s11_i_ff,   s11_i_in;

   logic              s12_bad_ff, s12_bad_in;
   logic [JDN_W-1:0]  s12_jd_ff,  s12_jd_in;
   logic [9:0]        s12_l3_ff,  s12_l3_in;
   logic [13:0]       s12_yc_ff,  s12_yc_in;

   logic              s13_bad_ff, s13_bad_in;
   logic [JDN_W-1:0]  s13_jd_ff,  s13_jd_in;
   logic [9:0]        s13_l3_ff,  s13_l3_in;
   logic [13:0]       s13_yc_ff,  s13_yc_in;
   logic [18:0]       s13_mj_ff,  s13_mj_in;
   logic [14:0]       s13_x3_ff,  s13_x3_in;

   logic              s14_bad_ff, s14_bad_in;
   logic [JDN_W-1:0]  s14_jd_ff,  s14_jd_in;
   logic [9:0]        s14_l3_ff,  s14_l3_in;
   logic [13:0]       s14_yc_ff,  s14_yc_in;
   logic [14:0]       s14_x3_ff,  s14_x3_in;
   logic [3:0]        s14_j_ff,   s14_j_in;
   logic [15:0]       s14_pj_ff,  s14_pj_in;

   logic              s15_bad_ff, s15_bad_in;
   logic [JDN_W-1:0]  s15_jd_ff,  s15_jd_in;
   logic [9:0]        s15_l3_ff,  s15_l3_in;
   logic [13:0]       s15_yc_ff,  s15_yc_in;
   logic [3:0]        s15_j_ff,   s15_j_in;

   logic              s16_bad_ff, s16_bad_in;
   logic [JDN_W-1:0]  s16_jd_ff,  s16_jd_in;
   logic [YEAR_W-1:0] s16_y_ff,   s16_y_in;
   logic [MONTH_W-1:0] s16_m_ff,  s16_m_in;
   logic [DAY_W-1:0]  s16_d_ff,   s16_d_in;

   logic              s17_bad_ff, s17_bad_in;
   logic [JDN_W-1:0]  s17_jd_ff,  s17_jd_in;
   logic [YEAR_W-1:0] s17_y_ff,   s17_y_in;
   logic [MONTH_W-1:0] s17_m_ff,  s17_m_in;
   logic [DAY_W-1:0]  s17_d_ff,   s17_d_in;
   logic [26:0]       s17_ym_ff,  s17_ym_in;

   // output register and skid
   rsp_word_type      out_word_ff,  out_word_in;
   rsp_word_type      skid_word_ff, skid_word_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_word_type      new_word;

   // combinational temporaries
   logic              s1_borrow;
   logic [7:0]        s3_cen;
   logic [9:0]        s3_t3w;
   logic [23:0]       s3_sum;
   logic [25:0]       s7_rem;
   logic              s7_cor;
   logic [25:0]       s8_pn3;
   logic [23:0]       s8_l2w;
   logic [16:0]       s9_a;
   logic [28:0]       s11_rem;
   logic              s11_cor;
   logic [17:0]       s12_pi4;
   logic [15:0]       s12_l3w;
   logic [15:0]       s15_rem;
   logic              s15_cor;
   logic              s16_l4;
   logic [9:0]        s16_dw;
   logic [7:0]        fin_cen;
   logic [13:0]       fin_rem;
   logic              fin_leap;

   // pipeline moves whenever the skid register is free
   assign advance    = !skid_valid_ff;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && advance;
   assign take       = out_valid_ff && !rsp_stall;
   assign leave      = stage_valid_ff[STAGES-1] && advance;

   // stage 1: range check, year offsets, month term
   always_comb begin
      s1_borrow = (req_in_month <= 4'd2);
      s1_op_in  = req_opcode;
      if (req_opcode == OP_JDN_TO_DATE) begin
         s1_bad_in = (req_in_day_number < JDN_MIN) || (req_in_day_number > JDN_MAX);
      end else begin
         s1_bad_in = (req_in_year == 14'd0) || (req_in_year > YEAR_MAX) ||
                     (req_in_month == 4'd0) || (req_in_month > MONTH_MAX) ||
                     (req_in_day == 5'd0);
      end
      s1_ya_in  = req_in_year + 14'd4800 - {13'd0, s1_borrow};
      s1_yb_in  = req_in_year + 14'd4900 - {13'd0, s1_borrow};
      s1_k1_in  = {1'b0, month_term(req_in_month)} + {5'd0, req_in_day};
      s1_jdi_in = req_in_day_number;
   end

   // stage 2: 1461 * year, year / 100 by reciprocal
   always_comb begin
      s2_op_in  = s1_op_ff;
      s2_bad_in = s1_bad_ff;
      s2_p1_in  = {11'd0, s1_ya_ff} * 25'd1461;
      s2_cm_in  = {13'd0, s1_yb_ff} * 27'd5243;
      s2_k1_in  = s1_k1_ff;
      s2_jdi_in = s1_jdi_ff;
   end

   // stage 3: sum of the date terms, opcode select
   always_comb begin
      s3_cen    = s2_cm_ff[26:19];
      s3_t3w    = {2'b00, s3_cen} + {1'b0, s3_cen, 1'b0};
      s3_sum    = {1'b0, s2_p1_ff[24:2]} + {14'd0, s2_k1_ff} - {16'd0, s3_t3w[9:2]}
                  - 24'd32075;
      s3_bad_in = s2_bad_ff;
      s3_jd_in  = (s2_op_ff == OP_JDN_TO_DATE) ? s2_jdi_ff : s3_sum[22:0];
   end

   // stages 4 to 7: n = 4l / 146097
   always_comb begin
      s4_bad_in = s3_bad_ff;
      s4_jd_in  = s3_jd_ff;
      s4_l_in   = s3_jd_ff + 23'd68569;

      s5_bad_in = s4_bad_ff;
      s5_jd_in  = s4_jd_ff;
      s5_l_in   = s4_l_ff;
      s5_mq_in  = {10'd0, s4_l_ff} * 33'd916;

      s6_bad_in = s5_bad_ff;
      s6_jd_in  = s5_jd_ff;
      s6_l_in   = s5_l_ff;
      s6_q_in   = s5_mq_ff[32:25];
      s6_pr_in  = {18'd0, s5_mq_ff[32:25]} * 26'd146097;

      s7_rem    = {1'b0, s6_l_ff, 2'b00} - s6_pr_ff;
      s7_cor    = (s7_rem >= 26'd146097);
      s7_bad_in = s6_bad_ff;
      s7_jd_in  = s6_jd_ff;
      s7_l_in   = s6_l_ff;
      s7_n_in   = s6_q_ff + {7'd0, s7_cor};
      s7_pn_in  = s7_cor ? (s6_pr_ff + 26'd146097) : s6_pr_ff;
   end

   // stages 8 to 11: day within the 400-year cycle, i = 4000 (l + 1) / 1461001
   always_comb begin
      s8_pn3    = s7_pn_ff + 26'd3;
      s8_l2w    = {1'b0, s7_l_ff} - s8_pn3[25:2];
      s8_bad_in = s7_bad_ff;
      s8_jd_in  = s7_jd_ff;
      s8_n_in   = s7_n_ff;
      s8_l2_in  = s8_l2w[15:0];

      s9_a      = {1'b0, s8_l2_ff} + 17'd1;
      s9_bad_in = s8_bad_ff;
      s9_jd_in  = s8_jd_ff;
      s9_n_in   = s8_n_ff;
      s9_l2_in  = s8_l2_ff;
      s9_mi_in  = {19'd0, s9_a} * 36'd732000;
      s9_x2_in  = {11'd0, s9_a} * 28'd4000;

      s10_bad_in = s9_bad_ff;
      s10_jd_in  = s9_jd_ff;
      s10_n_in   = s9_n_ff;
      s10_l2_in  = s9_l2_ff;
      s10_x2_in  = s9_x2_ff;
      s10_i_in   = s9_mi_ff[35:28];
      s10_pi_in  = {21'd0, s9_mi_ff[35:28]} * 29'd1461001;

      s11_rem    = {1'b0, s10_x2_ff} - s10_pi_ff;
      s11_cor    = (s11_rem >= 29'd1461001);
      s11_bad_in = s10_bad_ff;
      s11_jd_in  = s10_jd_ff;
      s11_n_in   = s10_n_ff;
      s11_l2_in  = s10_l2_ff;
      s11_i_in   = s10_i_ff + {7'd0, s11_cor};
   end

   // stages 12 to 15: day of year, j = 80 l / 2447
   always_comb begin
      s12_pi4    = {10'd0, s11_i_ff} * 18'd1461;
      s12_l3w    = s11_l2_ff - s12_pi4[17:2] + 16'd31;
      s12_bad_in = s11_bad_ff;
      s12_jd_in  = s11_jd_ff;
      s12_l3_in  = s12_l3w[9:0];
      s12_yc_in  = ({6'd0, s11_n_ff} - 14'd49) * 14'd100 + {6'd0, s11_i_ff};

      s13_bad_in = s12_bad_ff;
      s13_jd_in  = s12_jd_ff;
      s13_l3_in  = s12_l3_ff;
      s13_yc_in  = s12_yc_ff;
      s13_mj_in  = {9'd0, s12_l3_ff} * 19'd1040;
      s13_x3_in  = {5'd0, s12_l3_ff} * 15'd80;

      s14_bad_in = s13_bad_ff;
      s14_jd_in  = s13_jd_ff;
      s14_l3_in  = s13_l3_ff;
      s14_yc_in  = s13_yc_ff;
      s14_x3_in  = s13_x3_ff;
      s14_j_in   = s13_mj_ff[18:15];
      s14_pj_in  = {12'd0, s13_mj_ff[18:15]} * 16'd2447;

      s15_rem    = {1'b0, s14_x3_ff} - s14_pj_ff;
      s15_cor    = (s15_rem >= 16'd2447);
      s15_bad_in = s14_bad_ff;
      s15_jd_in  = s14_jd_ff;
      s15_l3_in  = s14_l3_ff;
      s15_yc_in  = s14_yc_ff;
      s15_j_in   = s14_j_ff + {3'd0, s15_cor};
   end

   // stage 16: year, month and day; stage 17: year / 100 for the leap rule
   always_comb begin
      s16_l4     = (s15_j_ff >= 4'd11);
      s16_dw     = s15_l3_ff - {1'b0, j_term(s15_j_ff)};
      s16_bad_in = s15_bad_ff;
      s16_jd_in  = s15_jd_ff;
      s16_d_in   = s16_dw[4:0];
      s16_m_in   = s16_l4 ? (s15_j_ff - 4'd10) : (s15_j_ff + 4'd2);
      s16_y_in   = s15_yc_ff + {13'd0, s16_l4};

      s17_bad_in = s16_bad_ff;
      s17_jd_in  = s16_jd_ff;
      s17_y_in   = s16_y_ff;
      s17_m_in   = s16_m_ff;
      s17_d_in   = s16_d_ff;
      s17_ym_in  = {13'd0, s16_y_ff} * 27'd5243;
   end

   // leap flag, month length and result word
   always_comb begin
      fin_cen  = s17_ym_ff[26:19];
      fin_rem  = s17_y_ff - ({6'd0, fin_cen} * 14'd100);
      fin_leap = (s17_y_ff[1:0] == 2'b00) && ((fin_rem != 14'd0) || (fin_cen[1:0] == 2'b00));
      new_word = '0;
      if (s17_bad_ff) begin
         new_word.out_of_range = 1'b1;
      end else begin
         new_word.day_number   = s17_jd_ff;
         new_word.year         = s17_y_ff;
         new_word.month        = s17_m_ff;
         new_word.day          = s17_d_ff;
         new_word.leap         = fin_leap;
         new_word.month_length = month_days(s17_m_ff, fin_leap);
      end
   end

   // output register and skid steering
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = leave;
         if (leave) begin
            out_word_in = new_word;
         end
      end else if (leave) begin
         skid_valid_in = 1'b1;
         skid_word_in  = new_word;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            stage_valid_ff <= {stage_valid_ff[STAGES-2:0], req_accept};
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff   <= s1_op_in;   s1_bad_ff  <= s1_bad_in;  s1_ya_ff   <= s1_ya_in;
         s1_yb_ff   <= s1_yb_in;   s1_k1_ff   <= s1_k1_in;   s1_jdi_ff  <= s1_jdi_in;

         s2_op_ff   <= s2_op_in;   s2_bad_ff  <= s2_bad_in;  s2_p1_ff   <= s2_p1_in;
         s2_cm_ff   <= s2_cm_in;   s2_k1_ff   <= s2_k1_in;   s2_jdi_ff  <= s2_jdi_in;

         s3_bad_ff  <= s3_bad_in;  s3_jd_ff   <= s3_jd_in;

         s4_bad_ff  <= s4_bad_in;  s4_jd_ff   <= s4_jd_in;   s4_l_ff    <= s4_l_in;

         s5_bad_ff  <= s5_bad_in;  s5_jd_ff   <= s5_jd_in;   s5_l_ff    <= s5_l_in;
         s5_mq_ff   <= s5_mq_in;

         s6_bad_ff  <= s6_bad_in;  s6_jd_ff   <= s6_jd_in;   s6_l_ff    <= s6_l_in;
         s6_q_ff    <= s6_q_in;    s6_pr_ff   <= s6_pr_in;

         s7_bad_ff  <= s7_bad_in;  s7_jd_ff   <= s7_jd_in;   s7_l_ff    <= s7_l_in;
         s7_n_ff    <= s7_n_in;    s7_pn_ff   <= s7_pn_in;

         s8_bad_ff  <= s8_bad_in;  s8_jd_ff   <= s8_jd_in;   s8_n_ff    <= s8_n_in;
         s8_l2_ff   <= s8_l2_in;

         s9_bad_ff  <= s9_bad_in;  s9_jd_ff   <= s9_jd_in;   s9_n_ff    <= s9_n_in;
         s9_l2_ff   <= s9_l2_in;   s9_mi_ff   <= s9_mi_in;   s9_x2_ff   <= s9_x2_in;

         s10_bad_ff <= s10_bad_in; s10_jd_ff  <= s10_jd_in;  s10_n_ff   <= s10_n_in;
         s10_l2_ff  <= s10_l2_in;  s10_x2_ff  <= s10_x2_in;  s10_i_ff   <= s10_i_in;
         s10_pi_ff  <= s10_pi_in;

         s11_bad_ff <= s11_bad_in; s11_jd_ff  <= s11_jd_in;  s11_n_ff   <= s11_n_in;
         s11_l2_ff  <= s11_l2_in;  s11_i_ff   <= s11_i_in;

         s12_bad_ff <= s12_bad_in; s12_jd_ff  <= s12_jd_in;  s12_l3_ff  <= s12_l3_in;
         s12_yc_ff  <= s12_yc_in;

         s13_bad_ff <= s13_bad_in; s13_jd_ff  <= s13_jd_in;  s13_l3_ff  <= s13_l3_in;
         s13_yc_ff  <= s13_yc_in;  s13_mj_ff  <= s13_mj_in;  s13_x3_ff  <= s13_x3_in;

         s14_bad_ff <= s14_bad_in; s14_jd_ff  <= s14_jd_in;  s14_l3_ff  <= s14_l3_in;
         s14_yc_ff  <= s14_yc_in;  s14_x3_ff  <= s14_x3_in;  s14_j_ff   <= s14_j_in;
         s14_pj_ff  <= s14_pj_in;

         s15_bad_ff <= s15_bad_in; s15_jd_ff  <= s15_jd_in;  s15_l3_ff  <= s15_l3_in;
         s15_yc_ff  <= s15_yc_in;  s15_j_ff   <= s15_j_in;

         s16_bad_ff <= s16_bad_in; s16_jd_ff  <= s16_jd_in;  s16_y_ff   <= s16_y_in;
         s16_m_ff   <= s16_m_in;   s16_d_ff   <= s16_d_in;

         s17_bad_ff <= s17_bad_in; s17_jd_ff  <= s17_jd_in;  s17_y_ff   <= s17_y_in;
         s17_m_ff   <= s17_m_in;   s17_d_ff   <= s17_d_in;   s17_ym_ff  <= s17_ym_in;
      end
   end

   // result ports
   assign rsp_valid             = out_valid_ff;
   assign rsp_result_day_number = out_word_ff.day_number;
   assign rsp_result_year       = out_word_ff.year;
   assign rsp_result_month      = out_word_ff.month;
   assign rsp_result_day        = out_word_ff.day;
   assign rsp_leap_year_flag    = out_word_ff.leap;
   assign rsp_month_length      = out_word_ff.month_length;
   assign rsp_out_of_range      = out_word_ff.out_of_range;

endmodule

// ===== hw/rtl/gdnc_checker.sv =====
module gdnc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [gdnc_pkg::YEAR_W-1:0]   req_in_year,
   input  logic [gdnc_pkg::MONTH_W-1:0]  req_in_month,
   input  logic [gdnc_pkg::DAY_W-1:0]    req_in_day,
   input  logic [gdnc_pkg::JDN_W-1:0]    req_in_day_number,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [gdnc_pkg::JDN_W-1:0]    rsp_result_day_number,
   input  logic [gdnc_pkg::YEAR_W-1:0]   rsp_result_year,
   input  logic [gdnc_pkg::MONTH_W-1:0]  rsp_result_month,
   input  logic [gdnc_pkg::DAY_W-1:0]    rsp_result_day,
   input  logic                          rsp_leap_year_flag,
   input  logic [gdnc_pkg::LEN_W-1:0]    rsp_month_length,
   input  logic                          rsp_out_of_range
);
   import gdnc_pkg::*;

   logic req_unused;
   assign req_unused = req_valid ^ req_opcode ^ (^req_in_year) ^ (^req_in_month) ^
                       (^req_in_day) ^ (^req_in_day_number);

   // a stalled result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_day_number) &&
      $stable(rsp_result_year) && $stable(rsp_out_of_range))
      else $error("stalled result word changed");

   // a rejected word carries nothing else
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_result_day_number == '0 &&
      rsp_result_year == '0 && rsp_result_month == '0 && rsp_result_day == '0 &&
      !rsp_leap_year_flag && rsp_month_length == '0)
      else $error("out-of-range word has non-zero fields");

   // a good word holds a real date within range
   a_date_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_result_month >= 4'd1 &&
      rsp_result_month <= MONTH_MAX && rsp_result_day >= 5'd1 &&
      rsp_result_day <= rsp_month_length && rsp_month_length >= 5'd28 &&
      rsp_result_day_number >= JDN_MIN && rsp_result_day_number <= JDN_MAX)
      else $error("result date out of range");

   // February length follows the leap flag
   a_feb_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range && rsp_result_month == 4'd2 |->
      rsp_month_length == (rsp_leap_year_flag ? 5'd29 : 5'd28))
      else $error("February length disagrees with leap flag");

   // reset empties the output side and releases the input
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall && !req_unused === !req_unused)
      else $error("output not empty after reset");

endmodule

bind gregorian_day_number_convert_unit gdnc_checker u_gdnc_checker (.*);

// ===== tb/day_number_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts each result word and compares
module day_number_check
   import gdnc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_opcode,
   input  logic [YEAR_W-1:0]  req_in_year,
   input  logic [MONTH_W-1:0] req_in_month,
   input  logic [DAY_W-1:0]   req_in_day,
   input  logic [JDN_W-1:0]   req_in_day_number,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [JDN_W-1:0]   rsp_result_day_number,
   input  logic [YEAR_W-1:0]  rsp_result_year,
   input  logic [MONTH_W-1:0] rsp_result_month,
   input  logic [DAY_W-1:0]   rsp_result_day,
   input  logic               rsp_leap_year_flag,
   input  logic [LEN_W-1:0]   rsp_month_length,
   input  logic               rsp_out_of_range,
   output int                 outstanding,
   output int                 mismatches
);

   // result words still owed by the block, oldest first
   rsp_word_type expected_dates[$];

   // date <-> day number conversion, integer arithmetic truncating towards zero
   function automatic rsp_word_type convert_date(input logic               op,
                                                 input logic [YEAR_W-1:0]  year_in,
                                                 input logic [MONTH_W-1:0] month_in,
                                                 input logic [DAY_W-1:0]   day_in,
                                                 input logic [JDN_W-1:0]   jdn_in);
      longint y, m, d, jd, a, l, n, i, j;
      bit leap;
      rsp_word_type w;
      w = '0;
      if (op == OP_DATE_TO_JDN) begin
         y = year_in;
         m = month_in;
         d = day_in;
         if (y < 1 || y > YEAR_MAX || m < 1 || m > MONTH_MAX || d < 1) begin
            w.out_of_range = 1'b1;
            return w;
         end
         // Jan and Feb count as months 11 and 12 of the previous year
         a = (m <= 2) ? 1 : 0;
         jd = (1461 * (y + 4800 - a)) / 4 + (367 * (m - 2 + 12 * a)) / 12
              - (3 * ((y + 4900 - a) / 100)) / 4 + d - 32075;
      end else begin
         jd = jdn_in;
         if (jd < JDN_MIN || jd > JDN_MAX) begin
            w.out_of_range = 1'b1;
            return w;
         end
      end

      // back to a date; also normalises days past the month end
      l = jd + 68569;
      n = (4 * l) / 146097;
      l = l - (146097 * n + 3) / 4;
      i = (4000 * (l + 1)) / 1461001;
      l = l - (1461 * i) / 4 + 31;
      j = (80 * l) / 2447;
      d = l - (2447 * j) / 80;
      l = j / 11;
      m = j + 2 - 12 * l;
      y = 100 * (n - 49) + i + l;

      leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      w.day_number = jd[JDN_W-1:0];
      w.year       = y[YEAR_W-1:0];
      w.month      = m[MONTH_W-1:0];
      w.day        = d[DAY_W-1:0];
      w.leap       = leap;
      case (m)
         2:             w.month_length = leap ? 5'd29 : 5'd28;
         4, 6, 9, 11:   w.month_length = 5'd30;
         default:       w.month_length = 5'd31;
      endcase
      return w;
   endfunction

   // one field of a word; X or Z in the actual value counts as wrong
   function automatic int field_mismatch(input string name, input logic [63:0] exp_val,
                                         input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   // queue on request acceptance, compare on result acceptance
   always @(posedge clock) begin : track
      rsp_word_type want;
      int errs;
      errs = 0;
      if (reset) begin
         expected_dates.delete();
         outstanding <= 0;
         mismatches  <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_dates.push_back(convert_date(req_opcode, req_in_year, req_in_month,
                                                  req_in_day, req_in_day_number));
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               $display("%0t: result word with none expected, expected none, actual %0d",
                        $time, rsp_result_day_number);
               errs++;
            end else begin
               want = expected_dates.pop_front();
               errs += field_mismatch("day_number", want.day_number, rsp_result_day_number);
               errs += field_mismatch("year", want.year, rsp_result_year);
               errs += field_mismatch("month", want.month, rsp_result_month);
               errs += field_mismatch("day", want.day, rsp_result_day);
               errs += field_mismatch("leap_year_flag", want.leap, rsp_leap_year_flag);
               errs += field_mismatch("month_length", want.month_length, rsp_month_length);
               errs += field_mismatch("out_of_range", want.out_of_range, rsp_out_of_range);
            end
         end
         outstanding <= expected_dates.size();
         mismatches  <= mismatches + errs;
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import gdnc_pkg::*;

   localparam int WORDS_PER_PHASE = 180;
   localparam int QUIET_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 30;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = OP_DATE_TO_JDN;
   logic [YEAR_W-1:0]  req_in_year = '0;
   logic [MONTH_W-1:0] req_in_month = '0;
   logic [DAY_W-1:0]   req_in_day = '0;
   logic [JDN_W-1:0]   req_in_day_number = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [JDN_W-1:0]   rsp_result_day_number;
   logic [YEAR_W-1:0]  rsp_result_year;
   logic [MONTH_W-1:0] rsp_result_month;
   logic [DAY_W-1:0]   rsp_result_day;
   logic               rsp_leap_year_flag;
   logic [LEN_W-1:0]   rsp_month_length;
   logic               rsp_out_of_range;

   int outstanding;
   int mismatches;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   gregorian_day_number_convert_unit dut (.*);

   day_number_check conversion_check (.*);

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request word, with random idle cycles first, and wait for it to go
   task automatic send_word(input logic op, input logic [YEAR_W-1:0] y,
                            input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                            input logic [JDN_W-1:0] jdn);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_in_year       <= y;
      req_in_month      <= m;
      req_in_day        <= d;
      req_in_day_number <= jdn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly legal dates and day numbers; the rest raw noise on every field
   task automatic send_random_word();
      logic               op;
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      logic [JDN_W-1:0]   jdn;
      op  = $urandom_range(0, 1);
      y   = $urandom;
      m   = $urandom;
      d   = $urandom;
      jdn = $urandom;
      if ($urandom_range(0, 9) < 8) begin
         if (op == OP_DATE_TO_JDN) begin
            // century years now and then to hit the leap rule's exceptions
            if ($urandom_range(0, 3) == 0)
               y = 100 * $urandom_range(1, 99);
            else
               y = $urandom_range(1, YEAR_MAX);
            m = $urandom_range(1, MONTH_MAX);
            d = $urandom_range(1, 31);
         end else begin
            jdn = $urandom_range(JDN_MIN, JDN_MAX);
         end
      end
      send_word(op, y, m, d, jdn);
   endtask

   // hold off until the block owes nothing
   task automatic wait_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct <= 63;

      // date to day number: range ends, leap rule, day overflow, bad fields
      send_word(OP_DATE_TO_JDN, 14'd1, 4'd1, 5'd1, $urandom);
      send_word(OP_DATE_TO_JDN, YEAR_MAX, MONTH_MAX, 5'd31, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2000, 4'd2, 5'd29, 23'h7FFFFF);
      send_word(OP_DATE_TO_JDN, 14'd1900, 4'd2, 5'd29, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2024, 4'd2, 5'd30, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2023, 4'd2, 5'd31, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2023, 4'd4, 5'd31, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd0, 4'd6, 5'd15, JDN_MIN);
      send_word(OP_DATE_TO_JDN, 14'd10000, 4'd1, 5'd1, $urandom);
      send_word(OP_DATE_TO_JDN, 14'h3FFF, 4'hF, 5'h1F, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2020, 4'd0, 5'd5, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2020, 4'd13, 5'd5, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2020, 4'd15, 5'd5, $urandom);
      send_word(OP_DATE_TO_JDN, 14'd2020, 4'd7, 5'd0, $urandom);

      // day number to date: range ends, just outside, extremes of the field
      send_word(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, JDN_MIN);
      send_word(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, JDN_MAX);
      send_word(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, JDN_MIN - 1);
      send_word(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, JDN_MAX + 1);
      send_word(OP_JDN_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 23'd0);
      send_word(OP_JDN_TO_DATE, 14'd0, 4'd0, 5'd0, 23'h7FFFFF);
      send_word(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, 23'd2451604);
      send_word(OP_JDN_TO_DATE, $urandom, $urandom, $urandom, 23'd2299161);

      // sender pause until the pipeline is empty
      wait_empty();
      repeat (WORDS_PER_PHASE) send_random_word();

      wait_empty();
      send_idle_pct = 63;
      recv_idle_pct <= 24;
      repeat (WORDS_PER_PHASE) send_random_word();

      wait_empty();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (WORDS_PER_PHASE) send_random_word();

      wait_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
